// ===== rtl/core/elc_pkg.sv =====
// ----------------------------------------------------------------------------
// Elevator LOOK controller package
// Shared constants, payload types and control types for the LOOK controller.
// ----------------------------------------------------------------------------
package elc_pkg;

	// Building size and derived widths.
	localparam int NUM_FLOORS = 32;
	localparam int FLOOR_W    = 5;
	localparam int TGT_W      = 6;
	localparam int REQ_W      = 6;
	localparam int DWELL_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// Marker for an empty target set.
	localparam logic [TGT_W-1:0] NO_TARGET = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_START_FLOOR = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [DWELL_W-1:0] DWELL_TICKS_RST = 8'd2;
	localparam logic [FLOOR_W-1:0] START_FLOOR_RST = 5'd0;

	// Item operation codes.
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic             op;
		logic [REQ_W-1:0] req_floor;
	} elc_in_t;

	typedef struct packed {
		logic [FLOOR_W-1:0] floor_now;
		logic [1:0]         travel_dir;
		logic               door_open;
		logic               arrived;
		logic               moved;
		logic [TGT_W-1:0]   highest_up_target;
		logic [TGT_W-1:0]   lowest_down_target;
		logic               rejected;
	} elc_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic exec;
	} elc_cmd_t;

endpackage

// ===== rtl/core/elc_chan_if.sv =====
// ----------------------------------------------------------------------------
// Elevator LOOK controller channel interface
// Valid/ready channel carrying one payload of a chosen type per transfer.
// ----------------------------------------------------------------------------
interface elc_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/elc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Elevator LOOK controller sequencer
// Two-state machine that captures an item and then executes it once the
// result register is free.
// ----------------------------------------------------------------------------
module elc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output elc_pkg::elc_cmd_t cmd
);
	import elc_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// The result register must be empty or emptying this cycle.
				if (!out_valid_q || out_ready) begin
					cmd.exec    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/elc_datapath.sv =====
// ----------------------------------------------------------------------------
// Elevator LOOK controller datapath
// Car state, target sets, dwell counter, configuration and result register.
// ----------------------------------------------------------------------------
module elc_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  elc_pkg::elc_cmd_t                cmd,
	input  elc_pkg::elc_in_t                 in_payload,
	input  logic                             cfg_we,
	input  logic [elc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [elc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output elc_pkg::elc_out_t                res_payload
);
	import elc_pkg::*;

	// Highest set bit, or the empty marker.
	function automatic logic [TGT_W-1:0] top_of(input logic [NUM_FLOORS-1:0] s);
		logic [TGT_W-1:0] r;
		r = NO_TARGET;
		for (int i = 0; i < NUM_FLOORS; i++) begin
			if (s[i]) r = TGT_W'(i);
		end
		return r;
	endfunction

	// Lowest set bit, or the empty marker.
	function automatic logic [TGT_W-1:0] bottom_of(input logic [NUM_FLOORS-1:0] s);
		logic [TGT_W-1:0] r;
		r = NO_TARGET;
		for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
			if (s[i]) r = TGT_W'(i);
		end
		return r;
	endfunction

	// Keep the direction while its set has work, else turn or go idle.
	function automatic dir_t resolve(input dir_t d, input logic up_any, input logic dn_any);
		dir_t r;
		case (d)
			DIR_UP:   r = up_any ? DIR_UP : (dn_any ? DIR_DOWN : DIR_IDLE);
			DIR_DOWN: r = dn_any ? DIR_DOWN : (up_any ? DIR_UP : DIR_IDLE);
			default:  r = DIR_IDLE;
		endcase
		return r;
	endfunction

	elc_in_t                in_q;
	logic [DWELL_W-1:0]     dwell_ticks_q;
	logic [FLOOR_W-1:0]     car_q;
	dir_t                   dir_q;
	logic [NUM_FLOORS-1:0]  up_q, down_q;
	logic [DWELL_W-1:0]     dwell_q;
	elc_out_t               res_q;

	logic [FLOOR_W-1:0]     car_d;
	dir_t                   dir_d;
	logic [NUM_FLOORS-1:0]  up_d, down_d;
	logic [DWELL_W-1:0]     dwell_d, dwell_load;
	logic                   arrived, moved, rejected;
	logic [FLOOR_W-1:0]     req_idx, start_clamped;
	logic [REQ_W-1:0]       car_ext;

	assign dwell_load = (dwell_ticks_q == '0) ? DWELL_W'(1) : dwell_ticks_q;
	assign req_idx    = in_q.req_floor[FLOOR_W-1:0];
	assign car_ext    = REQ_W'(car_q);
	assign start_clamped =
		({1'b0, cfg_wdata[FLOOR_W-1:0]} >= (FLOOR_W+1)'(NUM_FLOORS)) ?
		FLOOR_W'(NUM_FLOORS - 1) : cfg_wdata[FLOOR_W-1:0];

	always_comb begin
		car_d    = car_q;
		dir_d    = dir_q;
		up_d     = up_q;
		down_d   = down_q;
		dwell_d  = dwell_q;
		arrived  = 1'b0;
		moved    = 1'b0;
		rejected = 1'b0;
		if (in_q.op == OP_REQUEST) begin
			if (in_q.req_floor >= REQ_W'(NUM_FLOORS)) begin
				rejected = 1'b1;
			end else begin
				if (in_q.req_floor > car_ext) begin
					up_d[req_idx] = 1'b1;
				end else if (in_q.req_floor < car_ext) begin
					down_d[req_idx] = 1'b1;
				end else begin
					dwell_d = dwell_load;
				end
				if (dir_q == DIR_IDLE) begin
					if (up_d != '0) dir_d = DIR_UP;
					else if (down_d != '0) dir_d = DIR_DOWN;
				end
			end
		end else if (dwell_q != '0) begin
			dwell_d = dwell_q - DWELL_W'(1);
			if (dwell_d == '0) dir_d = resolve(dir_q, up_q != '0, down_q != '0);
		end else if (dir_q == DIR_UP || dir_q == DIR_DOWN) begin
			if (dir_q == DIR_UP && car_q != FLOOR_W'(NUM_FLOORS - 1)) begin
				car_d = car_q + FLOOR_W'(1);
				moved = 1'b1;
			end else if (dir_q == DIR_DOWN && car_q != '0) begin
				car_d = car_q - FLOOR_W'(1);
				moved = 1'b1;
			end
			if (dir_q == DIR_UP && up_q[car_d]) begin
				up_d[car_d] = 1'b0;
				arrived     = 1'b1;
				dwell_d     = dwell_load;
			end else if (dir_q == DIR_DOWN && down_q[car_d]) begin
				down_d[car_d] = 1'b0;
				arrived       = 1'b1;
				dwell_d       = dwell_load;
			end
			dir_d = resolve(dir_q, up_d != '0, down_d != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_ticks_q <= DWELL_TICKS_RST;
			car_q         <= START_FLOOR_RST;
			dir_q         <= DIR_IDLE;
			up_q          <= '0;
			down_q        <= '0;
			dwell_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DWELL_TICKS: begin
					dwell_ticks_q <= cfg_wdata[DWELL_W-1:0];
				end
				REG_START_FLOOR: begin
					car_q   <= start_clamped;
					dir_q   <= DIR_IDLE;
					up_q    <= '0;
					down_q  <= '0;
					dwell_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.exec) begin
			car_q   <= car_d;
			dir_q   <= dir_d;
			up_q    <= up_d;
			down_q  <= down_d;
			dwell_q <= dwell_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) in_q <= in_payload;
		if (cmd.exec) begin
			res_q.floor_now          <= car_d;
			res_q.travel_dir         <= dir_d;
			res_q.door_open          <= (dwell_d != '0);
			res_q.arrived            <= arrived;
			res_q.moved              <= moved;
			res_q.highest_up_target  <= top_of(up_d);
			res_q.lowest_down_target <= bottom_of(down_d);
			res_q.rejected           <= rejected;
		end
	end

	assign res_payload = res_q;

endmodule

// ===== rtl/core/elevator_look_controller.sv =====
// ----------------------------------------------------------------------------
// Elevator LOOK controller
// Single-car LOOK scheduler driven by floor requests and timer ticks.
// ----------------------------------------------------------------------------
// Each transfer on the item channel is either a floor request or a timer tick,
// and each one yields exactly one transfer on the result channel with the
// car's floor, direction, door state and the extreme pending targets. An item
// is first captured and then drives the update of the car
// state, which also loads the result register. The update waits while an
// earlier result is still held in that register, so the item channel can take
// the next item while the previous result has not yet been taken. Writing the
// start floor register places the car there and clears all pending targets,
// the direction and the door; configuration writes belong to idle periods.
module elevator_look_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	elc_chan_if.sink                       item,
	elc_chan_if.source                     result,
	input  logic                           cfg_we,
	input  logic [elc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [elc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import elc_pkg::*;

	elc_cmd_t cmd;
	elc_out_t res_payload;

	// The sequencer owns both handshakes; the datapath only sees commands.
	elc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// All car state, the target sets and the result register live here.
	elc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_payload  (item.payload),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.res_payload (res_payload)
	);

	assign result.payload = res_payload;

endmodule

// ===== rtl/core/elc_checker.sv =====
// ----------------------------------------------------------------------------
// Elevator LOOK controller checker
// Port-level assertions on the controller, attached by a bind statement.
// ----------------------------------------------------------------------------
module elc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              res_valid,
	input logic              res_ready,
	input elc_pkg::elc_out_t res_payload
);
	import elc_pkg::*;

	// A result that is offered stays offered until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before transfer");

	// One item at a time: the cycle after an accepted item takes no other.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item channel ready right after a transfer");

	// A stop always opens the door, and a rejected request neither moves nor stops.
	a_stop_door: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_payload.arrived || res_payload.rejected) |->
		(!res_payload.arrived || res_payload.door_open) &&
		(!res_payload.rejected || (!res_payload.moved && !res_payload.arrived)))
		else $error("inconsistent stop or rejection flags");

	// Pending up targets lie above the car and down targets below it.
	a_target_side: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |->
		(res_payload.highest_up_target == NO_TARGET ||
		 res_payload.highest_up_target[FLOOR_W-1:0] > res_payload.floor_now) &&
		(res_payload.lowest_down_target == NO_TARGET ||
		 res_payload.lowest_down_target[FLOOR_W-1:0] < res_payload.floor_now))
		else $error("target on the wrong side of the car");

endmodule

bind elevator_look_controller elc_checker u_elc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_payload (result.payload)
);
